// ===== rtl/mrq_pkg.sv =====
// ----------------------------------------------------------------------------
// mrq_pkg
// Shared codes, widths and controller/datapath handshake types for the
// mailbox ring queue.
// ----------------------------------------------------------------------------
package mrq_pkg;

	localparam int OP_W     = 3;
	localparam int IN_MSG_W = 32;
	localparam int STS_W    = 2;
	localparam int CNT_W    = 5;
	localparam int CAP_W    = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_POST_TAIL = 3'd0;
	localparam logic [OP_W-1:0] OP_POST_HEAD = 3'd1;
	localparam logic [OP_W-1:0] OP_GET       = 3'd2;
	localparam logic [OP_W-1:0] OP_FLUSH     = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

	// result status codes
	localparam logic [STS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STS_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [STS_W-1:0] ST_WAITER = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // latch the input beat
		logic exec;     // apply the operation to the ring
		logic load;     // move the result into the output register
	} mrq_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free; // output register can take a result this cycle
	} mrq_sts_t;

endpackage

// ===== rtl/mrq_ifs.sv =====
// ----------------------------------------------------------------------------
// mrq channel interfaces
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface mrq_in_if
	import mrq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [IN_MSG_W-1:0] message;
	logic                tasks_waiting;

	modport source (output valid, output op, output message, output tasks_waiting,
		input ready);
	modport sink (input valid, input op, input message, input tasks_waiting,
		output ready);
endinterface

interface mrq_out_if
	import mrq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STS_W-1:0]    status;
	logic [IN_MSG_W-1:0] message_out;
	logic [CNT_W-1:0]    mail_count;

	modport source (output valid, output status, output message_out, output mail_count,
		input ready);
	modport sink (input valid, input status, input message_out, input mail_count,
		output ready);
endinterface

// ===== rtl/mrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrq_ctrl
// Sequencer: take one beat, execute it on the ring, hand the result to the
// output register.
// ----------------------------------------------------------------------------
module mrq_ctrl
	import mrq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  mrq_sts_t sts,
	output mrq_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LOAD = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				// slot read data is valid here; wait for room downstream
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/mrq_dp.sv =====
// ----------------------------------------------------------------------------
// mrq_dp
// Ring datapath: slot memory, head/tail indices, message count, capacity
// register and the result register.
// ----------------------------------------------------------------------------
module mrq_dp
	import mrq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int MSG_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CAP_W-1:0]    cfg_wdata,
	input  logic [OP_W-1:0]     in_op,
	input  logic [IN_MSG_W-1:0] in_message,
	input  logic                in_tasks_waiting,
	input  mrq_cmd_t            cmd,
	output mrq_sts_t            sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STS_W-1:0]    out_status,
	output logic [IN_MSG_W-1:0] out_message,
	output logic [CNT_W-1:0]    out_count
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// next index going forward, wrapping at the effective capacity
	function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] idx,
		input logic [CAP_W-1:0] cap);
		logic [IDX_W:0] n;
		n = {1'b0, idx} + {{IDX_W{1'b0}}, 1'b1};
		if (32'(n) >= 32'(cap) || 32'(n) >= DEPTH) begin
			return '0;
		end
		return n[IDX_W-1:0];
	endfunction

	logic [CAP_W-1:0]     cap_q, cap_eff;
	logic [OP_W-1:0]      op_q;
	logic [MSG_WIDTH-1:0] msg_q;
	logic                 wait_q;

	logic [IDX_W-1:0]     rd_idx_q, wr_idx_q, rd_idx_d, wr_idx_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;

	logic [STS_W-1:0]     res_status_q, res_status_d;
	logic                 res_get_q, res_get_d;
	logic [CNT_W-1:0]     res_count_q;

	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr;
	logic [MSG_WIDTH-1:0] mem [DEPTH];
	logic [MSG_WIDTH-1:0] rd_data_q;

	logic                 out_valid_q;
	logic [STS_W-1:0]     out_status_q;
	logic [IN_MSG_W-1:0]  out_msg_q;
	logic [CNT_W-1:0]     out_count_q;

	// capacity 0 acts as 1, anything above DEPTH acts as DEPTH
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CAP_W'(1);
		end else if (32'(cap_q) > DEPTH) begin
			cap_eff = CAP_W'(DEPTH);
		end else begin
			cap_eff = cap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			msg_q  <= MSG_WIDTH'(in_message);
			wait_q <= in_tasks_waiting;
		end
	end

	always_comb begin
		rd_idx_d     = rd_idx_q;
		wr_idx_d     = wr_idx_q;
		cnt_d        = cnt_q;
		res_status_d = ST_OK;
		res_get_d    = 1'b0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_waddr    = wr_idx_q;
		case (op_q)
			OP_POST_TAIL, OP_POST_HEAD: begin
				if (wait_q) begin
					res_status_d = ST_WAITER;
				end else if (cnt_q >= cap_eff) begin
					res_status_d = ST_FULL;
				end else begin
					mem_we = 1'b1;
					cnt_d  = cnt_q + CNT_W'(1);
					if (op_q == OP_POST_HEAD) begin
						if (rd_idx_q == '0) begin
							rd_idx_d = IDX_W'(cap_eff - CAP_W'(1));
						end else begin
							rd_idx_d = rd_idx_q - IDX_W'(1);
						end
						mem_waddr = rd_idx_d;
					end else begin
						wr_idx_d = step_fwd(wr_idx_q, cap_eff);
					end
				end
			end
			OP_GET: begin
				if (cnt_q != '0) begin
					mem_re    = 1'b1;
					res_get_d = 1'b1;
					cnt_d     = cnt_q - CNT_W'(1);
					rd_idx_d  = step_fwd(rd_idx_q, cap_eff);
				end else begin
					res_status_d = ST_EMPTY;
				end
			end
			OP_FLUSH: begin
				if (!wait_q) begin
					cnt_d    = '0;
					rd_idx_d = '0;
					wr_idx_d = '0;
				end
			end
			OP_CLEAR: begin
				cnt_d    = '0;
				rd_idx_d = '0;
				wr_idx_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			cnt_q    <= '0;
		end else if (cmd.exec) begin
			rd_idx_q <= rd_idx_d;
			wr_idx_q <= wr_idx_d;
			cnt_q    <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= res_status_d;
			res_get_q    <= res_get_d;
			res_count_q  <= cnt_d;
		end
	end

	// slot storage, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.exec && mem_we) begin
			mem[mem_waddr] <= msg_q;
		end
		if (cmd.exec && mem_re) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_count_q  <= res_count_q;
			out_msg_q    <= res_get_q ? IN_MSG_W'(rd_data_q) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_message = out_msg_q;
	assign out_count   = out_count_q;

endmodule

// ===== rtl/mailbox_ring_queue.sv =====
// ----------------------------------------------------------------------------
// mailbox_ring_queue
// Message mailbox kept as a ring of slots with head/tail post, get, flush
// and clear, and a programmable capacity.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents                         | handshake
//  --------+-----+---------------------------------------+------------
//  req     | in  | op, message, tasks_waiting            | valid/ready
//  rsp     | out | status, message_out, mail_count       | valid/ready
//  cfg     | in  | capacity                              | cfg_we only
//
//  One operation at a time: accept, execute and result load follow in turn. The
//  result is valid once the load has moved it into the output register, and
//  the next beat is taken only after the load; the slot memory's registered
//  read sets the load step.
//  A result waits in the output register while the next beat is accepted and
//  executed; only the load step stalls on a full output register.
//  Reset empties the ring and sets capacity to 16; slot contents are not reset.
// ----------------------------------------------------------------------------
module mailbox_ring_queue
	import mrq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int MSG_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	mrq_in_if.sink           req,
	mrq_out_if.source        rsp
);

	mrq_cmd_t cmd;
	mrq_sts_t sts;

	mrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mrq_dp #(
		.DEPTH     (DEPTH),
		.MSG_WIDTH (MSG_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_op            (req.op),
		.in_message       (req.message),
		.in_tasks_waiting (req.tasks_waiting),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (rsp.valid),
		.out_ready        (rsp.ready),
		.out_status       (rsp.status),
		.out_message      (rsp.message_out),
		.out_count        (rsp.mail_count)
	);

endmodule

// ===== rtl/mrq_checker.sv =====
// ----------------------------------------------------------------------------
// mrq_checker
// Port-level checks on the mailbox ring queue, bound to the top level.
// ----------------------------------------------------------------------------
module mrq_checker
	import mrq_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic [STS_W-1:0]    out_status,
	input logic [IN_MSG_W-1:0] out_message,
	input logic [CNT_W-1:0]    out_count
);

	// only a successful get carries a message word
	a_msg_only_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_message != '0 |-> out_status == ST_OK)
		else $error("message word on a non-ok result");

	// an empty report leaves nothing stored
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_EMPTY |-> out_count == '0)
		else $error("empty status with nonzero count");

	// a full refusal means messages are stored
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status == ST_FULL |-> out_count != '0)
		else $error("full status with zero count");

	// a fresh result must follow an accepted beat
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 3))
		else $error("result appeared without a matching beat");

	// one operation in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while busy");

endmodule

bind mailbox_ring_queue mrq_checker u_mrq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (req.valid),
	.in_ready    (req.ready),
	.out_valid   (rsp.valid),
	.out_status  (rsp.status),
	.out_message (rsp.message_out),
	.out_count   (rsp.mail_count)
);

// ===== verif/mailbox_reply_checker.sv =====
// ----------------------------------------------------------------------------
// mailbox_reply_checker
// Watches the request and reply channels of the mailbox ring queue, keeps its
// own copy of the ring, index and count state, predicts one reply per
// accepted request beat and compares every reply beat field by field.
// ----------------------------------------------------------------------------
module mailbox_reply_checker
	import mrq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata,
	mrq_in_if                req,
	mrq_out_if               rsp,
	output int               mismatches,
	output int               pending,
	output int               replies_checked,
	output int               full_hits,
	output int               empty_hits,
	output int               waiter_hits
);

	localparam int SLOTS      = 16;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [STS_W-1:0]    status;
		logic [IN_MSG_W-1:0] message_out;
		logic [CNT_W-1:0]    mail_count;
	} mail_reply_t;

	logic [IN_MSG_W-1:0] ring [SLOTS];
	int unsigned         head;
	int unsigned         tail;
	int unsigned         stored;
	logic [CAP_W-1:0]    capacity;
	mail_reply_t         awaited_replies [$];

	function automatic int unsigned ring_next(int unsigned idx, int unsigned cap);
		int unsigned n;
		n = idx + 1;
		return (n >= cap || n >= SLOTS) ? 0 : n;
	endfunction

	// applies one operation to the shadow ring and returns the reply it yields
	function automatic mail_reply_t mailbox_apply(logic [OP_W-1:0] op,
		logic [IN_MSG_W-1:0] msg, logic waiting);
		mail_reply_t r;
		int unsigned cap;
		// out-of-range capacity is clamped to 1..SLOTS
		cap = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_POST_TAIL, OP_POST_HEAD: begin
				if (waiting) begin
					r.status = ST_WAITER;
				end else if (stored >= cap) begin
					r.status = ST_FULL;
				end else begin
					if (op == OP_POST_HEAD) begin
						head = (head == 0) ? cap - 1 : head - 1;
						ring[head] = msg;
					end else begin
						ring[tail] = msg;
						tail = ring_next(tail, cap);
					end
					stored++;
				end
			end
			OP_GET: begin
				if (stored > 0) begin
					stored--;
					r.message_out = ring[head];
					head = ring_next(head, cap);
				end else begin
					r.status = ST_EMPTY;
				end
			end
			OP_FLUSH, OP_CLEAR: begin
				// flush leaves the ring alone while a task waits
				if (op == OP_CLEAR || !waiting) begin
					stored = 0;
					head = 0;
					tail = 0;
				end
			end
			default: ;
		endcase
		r.mail_count = CNT_W'(stored);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mail_reply_t want;
		if (!arst_n) begin
			head = 0;
			tail = 0;
			stored = 0;
			capacity = CAP_RESET;
			awaited_replies.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			// compare before pushing, so a stray reply never matches this edge's request
			if (rsp.valid && rsp.ready) begin
				replies_checked++;
				case (rsp.status)
					ST_FULL:   full_hits++;
					ST_EMPTY:  empty_hits++;
					ST_WAITER: waiter_hits++;
					default: ;
				endcase
				if (awaited_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("[%0t] reply beat with none expected: status %0d message %h count %0d",
							$realtime, rsp.status, rsp.message_out, rsp.mail_count);
				end else begin
					want = awaited_replies.pop_front();
					if (rsp.status !== want.status || rsp.message_out !== want.message_out ||
						rsp.mail_count !== want.mail_count) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("[%0t] reply mismatch (exp/got): status %0d/%0d message %h/%h count %0d/%0d",
								$realtime, want.status, rsp.status, want.message_out,
								rsp.message_out, want.mail_count, rsp.mail_count);
					end
				end
			end
			if (req.valid && req.ready)
				awaited_replies.push_back(mailbox_apply(req.op, req.message, req.tasks_waiting));
			pending = awaited_replies.size();
		end
	end

endmodule

// ===== verif/tb_mailbox_ring_queue.sv =====
// ----------------------------------------------------------------------------
// tb_mailbox_ring_queue
// Drives request beats into the mailbox ring queue under random idling on
// both channels: a directed pass over full, empty, waiter, flush, clear and
// unused-op cases, then random phases at several capacities, extremes among
// them. The reply checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_mailbox_ring_queue;
	import mrq_pkg::*;

	localparam int PHASES      = 10;
	localparam int PHASE_BEATS = 100;
	localparam int CYCLE_LIMIT = 400000;

	localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	logic             steady;   // no idling on either side
	int               cycles;
	int               beats_sent;
	int               cap_settings;
	int               mismatches;
	int               pending;
	int               replies_checked;
	int               full_hits;
	int               empty_hits;
	int               waiter_hits;

	logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd2,
		5'd17, 5'd7, 5'd4, 5'd15, 5'd3};

	mrq_in_if  req_ch ();
	mrq_out_if rsp_ch ();

	mailbox_ring_queue #(
		.DEPTH     (16),
		.MSG_WIDTH (32)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	mailbox_reply_checker reply_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.mismatches      (mismatches),
		.pending         (pending),
		.replies_checked (replies_checked),
		.full_hits       (full_hits),
		.empty_hits      (empty_hits),
		.waiter_hits     (waiter_hits)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycles, pending);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [IN_MSG_W-1:0] pick_message();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_beat(logic [OP_W-1:0] op, logic [IN_MSG_W-1:0] msg, logic waiting);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.op = op;
		req_ch.message = msg;
		req_ch.tasks_waiting = waiting;
		do @(posedge clk); while (!req_ch.ready);
		beats_sent++;
	endtask

	// stop sending and let every outstanding reply drain
	task automatic quiesce();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		cap_settings++;
	endtask

	// reply side: ready high for a beat, then a random stall
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				rsp_ch.ready = 1'b0;
				hold--;
			end else begin
				rsp_ch.ready = 1'b1;
				hold = idle_len();
			end
		end
	end

	initial begin
		int               r;
		int               post_pct;
		logic [OP_W-1:0]  op;
		logic [CAP_W-1:0] cap;
		cycles = 0;
		beats_sent = 0;
		cap_settings = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_POST_TAIL;
		req_ch.message = '0;
		req_ch.tasks_waiting = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty ring first, then fill every slot so no later read
		// can land on an unwritten one
		send_beat(OP_GET, '1, 1'b1);
		send_beat(OP_FLUSH, '0, 1'b0);
		for (int i = 0; i < 16; i++)
			send_beat(OP_POST_TAIL, (i == 0) ? '0 : (i == 1) ? '1 : $urandom(), 1'b0);
		send_beat(OP_POST_TAIL, $urandom(), 1'b0);
		send_beat(OP_POST_HEAD, $urandom(), 1'b0);
		send_beat(OP_POST_TAIL, '1, 1'b1);
		send_beat(OP_POST_HEAD, '0, 1'b1);
		send_beat(OP_FLUSH, '0, 1'b1);
		send_beat(OP_GET, '0, 1'b0);
		send_beat(OP_POST_HEAD, 32'hA5A5_5A5A, 1'b0);
		send_beat(OP_GET, '0, 1'b0);
		send_beat(OP_SPARE_FIRST, '1, 1'b1);
		send_beat(OP_SPARE_LAST, '1, 1'b0);
		send_beat(OP_CLEAR, '1, 1'b1);

		// random phases; capacity changes leave stored mail in place
		for (int p = 0; p < PHASES; p++) begin
			quiesce();
			cap = (p == 6) ? CAP_W'($urandom_range(0, 31)) : phase_caps[p];
			set_capacity(cap);
			steady = (p == 3 || p == 7);
			post_pct = $urandom_range(25, 80);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					op = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
				else if (r < 3)
					op = OP_CLEAR;
				else if (r < 5)
					op = OP_FLUSH;
				else if ($urandom_range(0, 99) < post_pct)
					op = $urandom_range(0, 1) ? OP_POST_HEAD : OP_POST_TAIL;
				else
					op = OP_GET;
				send_beat(op, pick_message(), $urandom_range(0, 99) < 15);
			end
		end
		steady = 1'b0;
		quiesce();

		$display("Sent %0d request beats over %0d capacity settings; %0d replies checked.",
			beats_sent, cap_settings, replies_checked);
		$display("Replies seen: %0d full, %0d empty, %0d handed to a waiter.",
			full_hits, empty_hits, waiter_hits);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
